>>> sv/gdas_pkg.sv
package gdas_pkg;

	// stamp footprint: 3x3 core first, then the 5x5 ring
	localparam int NPOS = 25;
	localparam int CORE_N = 9;
	localparam int POS_W = 5;

	// request codes
	localparam logic [1:0] REQ_STAMP = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_WIDTH = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;

	// floor(n/100) as (n*5243)>>19, exact for n below 43690
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;

	// drain length, spanning the last issued pixel's trip through the pipe to its write
	localparam int DRAIN_CYC = 3;

	typedef logic signed [2:0] offs_t;

	localparam offs_t POS_DX [NPOS] = '{
		-3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd0, 3'sd1,
		-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
		-3'sd2, 3'sd2, -3'sd2, 3'sd2, -3'sd2, 3'sd2,
		-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2
	};

	localparam offs_t POS_DY [NPOS] = '{
		-3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1,
		-3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2,
		-3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd1,
		3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2
	};

	// alpha factor in percent; ring entries apply to half alpha
	localparam logic [6:0] POS_MULT [NPOS] = '{
		7'd85, 7'd85, 7'd85, 7'd85, 7'd100, 7'd85, 7'd85, 7'd85, 7'd85,
		7'd40, 7'd55, 7'd70, 7'd55, 7'd40,
		7'd55, 7'd55, 7'd70, 7'd70, 7'd55, 7'd55,
		7'd40, 7'd55, 7'd70, 7'd55, 7'd40
	};

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic [POS_W-1:0] pos;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
	} status_t;

endpackage

>>> sv/gdas_ram.sv
module gdas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/gdas_ctrl.sv
module gdas_ctrl
	import gdas_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input status_t status,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [POS_W-1:0] cnt_q, cnt_d;
	logic [1:0] drn_q, drn_d;
	logic last;

	// a stamp walks all footprint positions, other requests only one
	assign last = (status.kind == REQ_STAMP) ? (cnt_q == POS_W'(NPOS - 1)) : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			drn_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			drn_q <= drn_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		drn_d = drn_q;
		unique case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (start) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				drn_d = '0;
				if (last) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DRAIN: begin
				drn_d = drn_q + 1'b1;
				if (drn_q == 2'(DRAIN_CYC - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		cmd.load = 1'b0;
		cmd.issue = 1'b0;
		cmd.pos = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
			end
			S_DRAIN: begin
			end
			S_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done strobe longer than one cycle");

	a_busy_ends_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("request ended without a result");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= POS_W'(NPOS - 1)) else $error("footprint counter out of range");
`endif

endmodule

>>> sv/gdas_dp.sv
module gdas_dp
	import gdas_pkg::*;
#(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output status_t status,
	input logic [1:0] req_type,
	input logic signed [11:0] pos_x,
	input logic signed [11:0] pos_y,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha_level,
	input logic [31:0] pixel_word,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [8:0] cfg_data,
	output logic [31:0] read_word,
	output logic [4:0] pixels_touched
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int WCAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
	localparam int HCAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

	function automatic logic [7:0] brighten(input logic [7:0] c);
		logic [8:0] v;
		v = {1'b0, c} + {2'b0, c[7:1]};
		return v[8] ? 8'hFF : v[7:0];
	endfunction

	// floor(v/255) for v up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	logic [8:0] width_q, height_q, ew, eh;
	logic [1:0] kind_q;
	logic signed [11:0] px_q, py_q;
	logic [7:0] cr_q, cg_q, cb_q, a_q;
	logic [31:0] word_q, read_word_q;
	logic [4:0] touched_q;

	// issue stage
	offs_t dx, dy;
	logic signed [12:0] xs, ys;
	logic x_in, y_in, kind_ok, hit0;
	logic [17:0] yw, lin0;
	logic [7:0] base0;
	logic [14:0] prod0;

	logic hit_s1, hit_s2, hit_s3;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3;
	logic [14:0] prod_s1;
	logic [27:0] k_full;
	logic [7:0] k_s2, kn;
	logic [31:0] dst_s2, rd_data, wdata;
	logic [15:0] sr, sg, sb, sr_s3, sg_s3, sb_s3;
	logic we;

	assign ew = (width_q > 9'(WCAP)) ? 9'(WCAP) : width_q;
	assign eh = (height_q > 9'(HCAP)) ? 9'(HCAP) : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH: width_q <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= REQ_STAMP;
		end else if (cmd.load) begin
			kind_q <= req_type;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pos_x;
			py_q <= pos_y;
			cr_q <= brighten(red);
			cg_q <= brighten(green);
			cb_q <= brighten(blue);
			a_q <= alpha_level;
			word_q <= pixel_word;
		end
	end

	assign status.kind = kind_q;

	assign dx = (kind_q == REQ_STAMP) ? POS_DX[cmd.pos] : 3'sd0;
	assign dy = (kind_q == REQ_STAMP) ? POS_DY[cmd.pos] : 3'sd0;
	assign xs = {px_q[11], px_q} + {{10{dx[2]}}, dx};
	assign ys = {py_q[11], py_q} + {{10{dy[2]}}, dy};
	assign x_in = !xs[12] && (xs[11:0] < {3'b0, ew});
	assign y_in = !ys[12] && (ys[11:0] < {3'b0, eh});
	assign yw = ys[8:0] * ew;
	assign lin0 = yw + {9'b0, xs[8:0]};

	always_comb begin
		case (kind_q)
			REQ_STAMP: kind_ok = (a_q != 8'd0);
			REQ_WRITE, REQ_READ: kind_ok = 1'b1;
			default: kind_ok = 1'b0;
		endcase
	end

	assign hit0 = cmd.issue && x_in && y_in && kind_ok;

	// ring pixels blend with half alpha
	assign base0 = (cmd.pos >= POS_W'(CORE_N)) ? {1'b0, a_q[7:1]} : a_q;
	assign prod0 = base0 * POS_MULT[cmd.pos];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
			hit_s2 <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			hit_s1 <= hit0;
			hit_s2 <= hit_s1;
			hit_s3 <= hit_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= AW'(lin0);
		prod_s1 <= prod0;
		addr_s2 <= addr_s1;
		k_s2 <= k_full[RECIP_SHIFT+7:RECIP_SHIFT];
		dst_s2 <= rd_data;
		addr_s3 <= addr_s2;
		sr_s3 <= sr;
		sg_s3 <= sg;
		sb_s3 <= sb;
	end

	assign k_full = prod_s1 * RECIP_100;

	assign kn = 8'd255 - k_s2;
	assign sr = cr_q * k_s2 + dst_s2[23:16] * kn;
	assign sg = cg_q * k_s2 + dst_s2[15:8] * kn;
	assign sb = cb_q * k_s2 + dst_s2[7:0] * kn;

	assign we = hit_s3 && (kind_q != REQ_READ);
	assign wdata = (kind_q == REQ_WRITE) ? word_q
		: {8'hFF, div255(sr_s3), div255(sg_s3), div255(sb_s3)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_word_q <= '0;
			touched_q <= '0;
		end else if (cmd.load) begin
			read_word_q <= '0;
			touched_q <= '0;
		end else begin
			if (hit_s1 && kind_q == REQ_READ) begin
				read_word_q <= rd_data;
			end
			if (we) begin
				touched_q <= touched_q + 1'b1;
			end
		end
	end

	assign read_word = read_word_q;
	assign pixels_touched = touched_q;

	gdas_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_frame (
		.clk(clk),
		.we(we),
		.waddr(addr_s3),
		.wdata(wdata),
		.re(hit0),
		.raddr(AW'(lin0)),
		.rdata(rd_data)
	);

`ifndef SYNTHESIS
	a_touched_max: assert property (@(posedge clk) disable iff (!arst_n)
		touched_q <= 5'(NPOS)) else $error("more pixels written than the footprint holds");

	a_single_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != REQ_STAMP) |-> (touched_q <= 5'd1))
		else $error("pixel request wrote more than one word");

	a_clear_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (touched_q == 5'd0))
		else $error("pixel count not cleared by a new request");
`endif

endmodule

>>> sv/glow_dot_alpha_stamp.sv
// glow dot stamp on a 32-bit ARGB framebuffer held in one on-chip memory
// request channel: start with req_type and its fields; a request is taken
// when start is high and busy is low, busy stays high until the result
// result channel: done is high for exactly one cycle with read_word and
// pixels_touched; the receiver takes it then and cannot hold it off
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is frame width, 1 frame height, others ignored; ready only while idle
// a stamp steps through its 25 footprint pixels one per cycle, each a
// read, a factor multiply, a blend multiply and a write-back in a 3-stage
// pipe behind the memory read port; done follows once the last pixel has
// drained from the pipe, and busy stays high until then, so no new request is taken
// write and read requests issue a single pixel through the same pipe
// the single memory write port sets the one pixel per cycle stamp rate
// reset: idle, width and height 256; framebuffer contents undefined until
// written
module glow_dot_alpha_stamp
	import gdas_pkg::*;
#(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] req_type,
	input logic signed [11:0] pos_x,
	input logic signed [11:0] pos_y,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha_level,
	input logic [31:0] pixel_word,
	output logic done,
	output logic [31:0] read_word,
	output logic [4:0] pixels_touched,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [8:0] cfg_data
);

	cmd_t cmd;
	status_t status;

	assign cfg_ready = !busy;

	gdas_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.status(status),
		.busy(busy),
		.done(done),
		.cmd(cmd)
	);

	gdas_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.req_type(req_type),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha_level(alpha_level),
		.pixel_word(pixel_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.read_word(read_word),
		.pixels_touched(pixels_touched)
	);

endmodule
